@@ hw/rtl/utrd_pkg.sv @@
`default_nettype none

package utrd_pkg;

  // Converted value width (low bits of the value field are used).
  localparam int unsigned VALUE_BITS = 64;

  // Fixed field widths.
  localparam int unsigned IN_VALUE_W    = 64;
  localparam int unsigned RADIX_W       = 6;
  localparam int unsigned CHAR_W        = 7;
  localparam int unsigned DIGIT_COUNT_W = 7;

  // Digit store sizing follows the value width: base 2 is the longest run.
  localparam int unsigned MAX_DIGITS = VALUE_BITS;
  localparam int unsigned ADDR_W     = $clog2(MAX_DIGITS);
  localparam int unsigned CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int unsigned BIT_CNT_W  = $clog2(VALUE_BITS + 1);

  localparam logic [RADIX_W-1:0] RADIX_MIN      = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX      = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] DECIMAL_LIMIT  = RADIX_W'(10);
  localparam logic [CHAR_W-1:0]  CHAR_ZERO      = CHAR_W'(48);
  localparam logic [CHAR_W-1:0]  CHAR_ALPHA_BASE = CHAR_W'(65 - 10);

  typedef struct packed {
    logic [IN_VALUE_W-1:0] value;
    logic [RADIX_W-1:0]    radix;
  } in_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0]        digit_char;
    logic [DIGIT_COUNT_W-1:0] digit_count;
    logic                     last;
  } out_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_RWAIT,
    ST_OUT
  } state_e;

  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = CHAR_W'(d);
    if (d < DECIMAL_LIMIT) begin
      return dx + CHAR_ZERO;
    end else begin
      return dx + CHAR_ALPHA_BASE;
    end
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/utrd_ram.sv @@
`default_nettype none

module utrd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/utrd_divider.sv @@
`default_nettype none

// Restoring bit-serial divider: one quotient bit per cycle.
// The dividend register shifts left and takes quotient bits at the bottom.
module utrd_divider
  import utrd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [VALUE_BITS-1:0] dividend_i,
  input  wire logic [RADIX_W-1:0]    divisor_i,
  output logic                       done_o,
  output logic      [VALUE_BITS-1:0] quotient_o,
  output logic      [RADIX_W-1:0]    remainder_o
);

  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic [RADIX_W-1:0]    rem_q, rem_d;
  logic [RADIX_W-1:0]    div_q;
  logic [BIT_CNT_W-1:0]  cnt_q;
  logic                  busy_q;
  logic                  done_q;

  logic [RADIX_W:0] trial;
  logic [RADIX_W:0] diff;
  logic             ge;

  always_comb begin
    trial = {rem_q, acc_q[VALUE_BITS-1]};
    ge    = trial >= {1'b0, div_q};
    diff  = trial - {1'b0, div_q};
    rem_d = ge ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
    acc_d = {acc_q[VALUE_BITS-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= BIT_CNT_W'(VALUE_BITS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - BIT_CNT_W'(1);
        if (cnt_q == BIT_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      rem_q <= rem_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = acc_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

@@ hw/rtl/unsigned_to_radix_digits_top.sv @@
`default_nettype none

// Unsigned-to-radix digit converter. Each input request carries a value (low
// VALUE_BITS bits used) and a radix; radix below 2 is taken as 2, above 36 as
// 36. The block emits one output request per digit, most significant first,
// as ASCII '0'-'9' then 'A'-'Z', each tagged with the total digit count and a
// last flag on the least significant digit. Zero gives the single digit '0'.
// Timing: one request at a time; in_stall_o stays high from acceptance until
// the last digit is taken. Division uses one bit-serial divider (one quotient
// bit per cycle, reused for every digit); each digit then passes the output
// side's digit store read, load and handoff states.
module unsigned_to_radix_digits_top
  import utrd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_req_t  in_req_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_req_t      out_req_o
);

  state_e state_q, state_d;

  // Saturated radix of the incoming request.
  logic [RADIX_W-1:0] radix_sat;
  logic [RADIX_W-1:0] radix_q;

  logic [CNT_W-1:0]  count_q;   // digits produced so far
  logic [ADDR_W-1:0] rd_idx_q;  // next digit to read, counts down to zero

  // Divider hookup
  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  logic [RADIX_W-1:0]    div_divisor;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quot;
  logic [RADIX_W-1:0]    div_rem;

  // Digit store
  logic              mem_we;
  logic              mem_re;
  logic [CHAR_W-1:0] mem_rdata;

  logic in_acc;
  logic out_acc;
  logic div_finish;

  logic              out_valid_q;
  logic [CHAR_W-1:0] out_char_q;
  logic              out_last_q;

  always_comb begin
    if (in_req_i.radix < RADIX_MIN) begin
      radix_sat = RADIX_MIN;
    end else if (in_req_i.radix > RADIX_MAX) begin
      radix_sat = RADIX_MAX;
    end else begin
      radix_sat = in_req_i.radix;
    end
  end

  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_o && !out_stall_i;
  // Conversion ends when the quotient runs out or the store is full.
  assign div_finish = (div_quot == '0) || (count_q == CNT_W'(MAX_DIGITS - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done && div_finish) state_d = ST_READ;
      end
      ST_READ: begin
        state_d = ST_RWAIT;
      end
      ST_RWAIT: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall_i) state_d = out_last_q ? ST_IDLE : ST_READ;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_stall_o   = 1'b1;
    div_start    = 1'b0;
    div_dividend = div_quot;
    div_divisor  = radix_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        div_start    = in_valid_i;
        div_dividend = in_req_i.value[VALUE_BITS-1:0];
        div_divisor  = radix_sat;
      end
      ST_DIV: begin
        mem_we    = div_done;
        div_start = div_done && !div_finish;
      end
      ST_READ: begin
        mem_re = 1'b1;
      end
      ST_RWAIT, ST_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      rd_idx_q    <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        count_q <= '0;
      end else if (mem_we) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (mem_we && div_finish) begin
        rd_idx_q <= count_q[ADDR_W-1:0];
      end else if (state_q == ST_OUT && out_acc && !out_last_q) begin
        rd_idx_q <= rd_idx_q - ADDR_W'(1);
      end
      if (state_q == ST_RWAIT) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      radix_q <= radix_sat;
    end
    if (state_q == ST_RWAIT) begin
      out_char_q <= mem_rdata;
      out_last_q <= (rd_idx_q == '0);
    end
  end

  utrd_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  // Digits are written least significant first and read back in reverse.
  utrd_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (MAX_DIGITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[ADDR_W-1:0]),
    .wdata_i (digit_to_char(div_rem)),
    .re_i    (mem_re),
    .raddr_i (rd_idx_q),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o           = out_valid_q;
  assign out_req_o.digit_char  = out_char_q;
  assign out_req_o.digit_count = DIGIT_COUNT_W'(count_q);
  assign out_req_o.last        = out_last_q;

  // A digit is only presented from the handoff state.
  a_out_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> state_q == ST_OUT)
    else $error("output valid outside handoff state");

  // No new request is taken while digits are still pending.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o && state_q == ST_IDLE)
    else $error("input open while a conversion is in flight");

  // Taking the last digit returns the block to idle.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && out_req_o.last |=> state_q == ST_IDLE)
    else $error("last digit did not end the run");

  // Digit count is at least one and within the store while presenting.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> count_q != '0 && count_q <= CNT_W'(MAX_DIGITS))
    else $error("digit count out of range");

endmodule

`default_nettype wire
